FILE: rtl/wg_pkg.sv
// ----------------------------------------------------------------------------
// wg_pkg
// Shared constants, register map and sine table function for the waveform
// generator.
// ----------------------------------------------------------------------------
package wg_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int MAX_SAMPLE_BITS     = 24;

    localparam int OUT_BITS   = 16;
    localparam int AMP_BITS   = 15;
    localparam int COUNT_BITS = 25;
    localparam int INDEX_BITS = 24;
    localparam int WAVE_BITS  = 2;
    localparam int DATA_BITS  = 32;
    localparam int PADDR_BITS = 5;
    localparam int REG_SEL_BITS = 3;

    // waveform codes
    localparam logic [WAVE_BITS-1:0] WAVE_SINE   = 2'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_COSINE = 2'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE = 2'd2;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW    = 2'd3;

    // register indexes, byte address is 4 * index
    localparam logic [REG_SEL_BITS-1:0] REG_WAVEFORM     = 3'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_PHASE_STEP   = 3'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_PHASE_OFFSET = 3'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_AMPLITUDE    = 3'd3;
    localparam logic [REG_SEL_BITS-1:0] REG_SAMPLE_COUNT = 3'd4;

    localparam logic [WAVE_BITS-1:0]  WAVEFORM_RST = WAVE_SINE;
    localparam logic [DATA_BITS-1:0]  STEP_RST     = 32'd42949673;
    localparam logic [DATA_BITS-1:0]  OFFSET_RST   = 32'd0;
    localparam logic [AMP_BITS-1:0]   AMP_RST      = 15'd32767;
    localparam logic [COUNT_BITS-1:0] COUNT_RST    = 25'd1024;
    localparam logic [COUNT_BITS-1:0] MAX_COUNT    = 25'd16777216;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // quarter-wave sine at index q of a table of 2^tab_bits entries, full scale
    // 2^(smp_bits-1)-1, q30 taylor series; only called with constant arguments
    function automatic logic [MAX_SAMPLE_BITS-1:0] quarter_sine(input int q,
                                                                input int tab_bits,
                                                                input int smp_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        full;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = ((64'd2 * PI_Q30) * 64'(q)) >> tab_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        full = (64'd1 << (smp_bits - 1)) - 64'd1;
        v    = (unsigned'(sum) * full + (64'd1 << 29)) >> 30;
        if (v > full)
        begin
            v = full;
        end
        return v[MAX_SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: rtl/wg_ram.sv
// ----------------------------------------------------------------------------
// wg_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module wg_ram #(
    parameter int WIDTH = wg_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = 1 << wg_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/waveform_generator.sv
// ----------------------------------------------------------------------------
// waveform_generator
// Phase-accumulator waveform source: sine, cosine, square or sawtooth samples
// scaled by a programmable amplitude, with a run counter flagging the last beat.
// ----------------------------------------------------------------------------
// One tick beat in gives one sample beat out. The block takes a tick every
// clock unless the output is stalled with both stages full. A tick forms the
// phase and reads the sine RAM into its registered output, then the wave is
// scaled into the output register. After reset the sine RAM is loaded from a
// constant quarter-wave table, one entry per cycle, so tick_stall stays high
// until all 2^TABLE_ADDR_BITS entries (1024 at the default size) are written;
// the APB port takes writes during that time. Registers sit at byte addresses
// 0x00 waveform, 0x04 phase_step, 0x08 phase_offset, 0x0c amplitude, 0x10
// sample_count and should only be written while no tick is in flight.
module waveform_generator #(
    parameter int PHASE_BITS      = wg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = wg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = wg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tick channel
    input  logic                              tick_valid,
    output logic                              tick_stall,
    input  logic                              restart,
    // sample channel
    output logic                              sample_valid,
    input  logic                              sample_stall,
    output logic signed [wg_pkg::OUT_BITS-1:0] sample,
    output logic                              last,
    // apb
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wg_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [wg_pkg::DATA_BITS-1:0]      pwdata,
    output logic [wg_pkg::DATA_BITS-1:0]      prdata,
    output logic                              pready
);

    localparam int TAB        = TABLE_ADDR_BITS;
    localparam int TABLE_SIZE = 1 << TAB;
    localparam int HALF       = TABLE_SIZE / 2;
    localparam int QTR        = TABLE_SIZE / 4;
    localparam int PW         = wg_pkg::AMP_BITS + SAMPLE_BITS + 1;
    localparam logic signed [PW-1:0] RND_HALF = PW'(longint'(1) << (SAMPLE_BITS - 2));

    localparam logic ST_FILL = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [wg_pkg::WAVE_BITS-1:0]  waveform_reg;
    logic [wg_pkg::DATA_BITS-1:0]  step_reg;
    logic [wg_pkg::DATA_BITS-1:0]  offset_reg;
    logic [wg_pkg::AMP_BITS-1:0]   amp_reg;
    logic [wg_pkg::COUNT_BITS-1:0] count_reg;
    logic                          cfg_wr;
    logic [wg_pkg::REG_SEL_BITS-1:0] reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[wg_pkg::PADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= wg_pkg::WAVEFORM_RST;
            step_reg     <= wg_pkg::STEP_RST;
            offset_reg   <= wg_pkg::OFFSET_RST;
            amp_reg      <= wg_pkg::AMP_RST;
            count_reg    <= wg_pkg::COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                wg_pkg::REG_WAVEFORM:     waveform_reg <= pwdata[wg_pkg::WAVE_BITS-1:0];
                wg_pkg::REG_PHASE_STEP:   step_reg     <= pwdata;
                wg_pkg::REG_PHASE_OFFSET: offset_reg   <= pwdata;
                wg_pkg::REG_AMPLITUDE:    amp_reg      <= pwdata[wg_pkg::AMP_BITS-1:0];
                wg_pkg::REG_SAMPLE_COUNT: count_reg    <= pwdata[wg_pkg::COUNT_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wg_pkg::REG_WAVEFORM:     prdata = wg_pkg::DATA_BITS'(waveform_reg);
            wg_pkg::REG_PHASE_STEP:   prdata = step_reg;
            wg_pkg::REG_PHASE_OFFSET: prdata = offset_reg;
            wg_pkg::REG_AMPLITUDE:    prdata = wg_pkg::DATA_BITS'(amp_reg);
            wg_pkg::REG_SAMPLE_COUNT: prdata = wg_pkg::DATA_BITS'(count_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sine RAM and its load sequence
    // ------------------------------------------------------------------
    logic                          state_reg;
    logic                          state_next;
    logic [TAB-1:0]                fill_cnt_reg;
    logic [TAB-1:0]                fill_cnt_next;
    logic signed [SAMPLE_BITS-1:0] qtab [0:QTR];
    logic [TAB-2:0]                fill_h;
    logic [TAB-1:0]                fill_mirror;
    logic [TAB-2:0]                fill_q;
    logic signed [SAMPLE_BITS-1:0] fill_val;
    logic signed [SAMPLE_BITS-1:0] fill_data;
    logic                          ram_we;
    logic                          ram_re;
    logic [TAB-1:0]                ram_raddr;
    logic signed [SAMPLE_BITS-1:0] rom_rdata;

    genvar g;
    generate
        for (g = 0; g <= QTR; g++)
        begin : g_qtab
            assign qtab[g] = SAMPLE_BITS'(wg_pkg::quarter_sine(g, TAB, SAMPLE_BITS));
        end
    endgenerate

    // second and fourth quarters mirror the first, second half is negated
    assign fill_h      = fill_cnt_reg[TAB-2:0];
    assign fill_mirror = TAB'(HALF) - {1'b0, fill_h};
    assign fill_q      = (fill_h > (TAB-1)'(QTR)) ? fill_mirror[TAB-2:0] : fill_h;
    assign fill_val    = qtab[fill_q];
    assign fill_data   = fill_cnt_reg[TAB-1] ? -fill_val : fill_val;
    assign ram_we      = (state_reg == ST_FILL);

    always_comb
    begin
        state_next    = state_reg;
        fill_cnt_next = fill_cnt_reg;
        case (state_reg)
            ST_FILL:
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                fill_cnt_next = fill_cnt_reg;
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    wg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_sine_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_cnt_reg),
        .wdata (fill_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rom_rdata)
    );

    // ------------------------------------------------------------------
    // stage 0: phase, run counter, table address
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [wg_pkg::INDEX_BITS-1:0] index_reg;
    logic [PHASE_BITS-1:0]         ph_cur;
    logic [wg_pkg::INDEX_BITS-1:0] idx_cur;
    logic [PHASE_BITS-1:0]         ph_sum;
    logic [TAB-1:0]                addr_base;
    logic [wg_pkg::COUNT_BITS-1:0] count_eff;
    logic [wg_pkg::COUNT_BITS-1:0] idx_inc;
    logic                          last_cur;
    logic signed [SAMPLE_BITS-1:0] saw_cur;
    logic                          accept;

    logic                          s1_valid_reg;
    logic                          s1_move;
    logic signed [SAMPLE_BITS-1:0] s1_saw_reg;
    logic                          s1_last_reg;

    assign tick_stall = (state_reg != ST_RUN) || (s1_valid_reg && sample_valid && sample_stall);
    assign accept     = tick_valid && !tick_stall;

    assign ph_cur    = restart ? '0 : phase_reg;
    assign idx_cur   = restart ? '0 : index_reg;
    assign ph_sum    = ph_cur + PHASE_BITS'(offset_reg);
    assign addr_base = ph_sum[PHASE_BITS-1 -: TAB];
    assign ram_raddr = addr_base + ((waveform_reg == wg_pkg::WAVE_COSINE) ? TAB'(QTR) : '0);
    assign ram_re    = accept;

    // zero count acts as one, count beyond the index reach saturates
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = wg_pkg::COUNT_BITS'(1);
        end
        else if (count_reg > wg_pkg::MAX_COUNT)
        begin
            count_eff = wg_pkg::MAX_COUNT;
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    assign idx_inc  = {1'b0, idx_cur} + wg_pkg::COUNT_BITS'(1);
    assign last_cur = (idx_inc >= count_eff);

    // sawtooth is the raw accumulator as a signed fraction, offset not applied
    generate
        if (PHASE_BITS >= SAMPLE_BITS)
        begin : g_saw_trunc
            assign saw_cur = ph_cur[PHASE_BITS-1 -: SAMPLE_BITS];
        end
        else
        begin : g_saw_pad
            assign saw_cur = {ph_cur, {(SAMPLE_BITS - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage 1: wave select and amplitude scaling
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0]     wave;
    logic signed [wg_pkg::AMP_BITS:0]  amp_s;
    logic signed [PW-1:0]              prod;
    logic signed [PW-1:0]              prod_rnd;
    logic signed [PW-1:0]              prod_shift;
    logic signed [wg_pkg::OUT_BITS-1:0] square_val;
    logic signed [wg_pkg::OUT_BITS-1:0] sample_next;

    assign s1_move    = s1_valid_reg && !(sample_valid && sample_stall);
    assign wave       = (waveform_reg == wg_pkg::WAVE_SAW) ? s1_saw_reg : rom_rdata;
    assign amp_s      = signed'({1'b0, amp_reg});
    assign prod       = amp_s * wave;
    assign prod_rnd   = prod + RND_HALF;
    assign prod_shift = prod_rnd >>> (SAMPLE_BITS - 1);
    assign square_val = rom_rdata[SAMPLE_BITS-1] ? -wg_pkg::OUT_BITS'(amp_s)
                                                 : wg_pkg::OUT_BITS'(amp_s);
    assign sample_next = (waveform_reg == wg_pkg::WAVE_SQUARE) ? square_val
                                                               : prod_shift[wg_pkg::OUT_BITS-1:0];

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            fill_cnt_reg <= '0;
            phase_reg    <= '0;
            index_reg    <= '0;
            s1_valid_reg <= 1'b0;
            sample_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
            if (accept)
            begin
                if (last_cur)
                begin
                    phase_reg <= '0;
                    index_reg <= '0;
                end
                else
                begin
                    phase_reg <= ph_cur + PHASE_BITS'(step_reg);
                    index_reg <= idx_inc[wg_pkg::INDEX_BITS-1:0];
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                sample_valid <= 1'b1;
            end
            else if (!sample_stall)
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_saw_reg  <= saw_cur;
            s1_last_reg <= last_cur;
        end
        if (s1_move)
        begin
            sample <= sample_next;
            last   <= s1_last_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_read_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("sine ram read while table load in progress");

    a_run_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_cur) |=> (phase_reg == '0 && index_reg == '0))
        else $error("phase or index did not wrap after last beat of a run");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=>
            (s1_valid_reg && $stable(s1_saw_reg) && $stable(s1_last_reg)))
        else $error("table read stage lost or changed a blocked item");

    a_fill_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_RUN) |-> ($past(fill_cnt_reg) == '1))
        else $error("table load ended before the last entry was written");
`endif

endmodule
